// ===== rtl/rsc_pkg.sv =====
// shared constants and types for the rv32i subset core
package rsc_pkg;

	localparam int MEM_BYTES_DEF = 65536;
	localparam int NUM_REGS_DEF  = 32;

	// request kinds
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_EXEC  = 2'd1;
	localparam logic [1:0] REQ_RDREG = 2'd2;
	localparam logic [1:0] REQ_RDMEM = 2'd3;

	// major opcodes
	localparam logic [6:0] OP_REG   = 7'h33;
	localparam logic [6:0] OP_IMM   = 7'h13;
	localparam logic [6:0] OP_LOAD  = 7'h03;
	localparam logic [6:0] OP_STORE = 7'h23;
	localparam logic [6:0] OP_BR    = 7'h63;
	localparam logic [6:0] OP_JAL   = 7'h6F;
	localparam logic [6:0] OP_JALR  = 7'h67;
	localparam logic [6:0] OP_LUI   = 7'h37;
	localparam logic [6:0] OP_AUIPC = 7'h17;
	localparam logic [6:0] F7_ALT   = 7'h20;
	localparam logic [31:0] UPPER_MASK = 32'hFFFFF000;

	// funct3 codes
	localparam logic [2:0] F3_ADD = 3'd0;
	localparam logic [2:0] F3_SLT = 3'd2;
	localparam logic [2:0] F3_XOR = 3'd4;
	localparam logic [2:0] F3_OR  = 3'd6;
	localparam logic [2:0] F3_AND = 3'd7;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;
	localparam logic [2:0] F3_BLT = 3'd4;
	localparam logic [2:0] F3_BGE = 3'd5;

	typedef logic [2:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 3'd0;
	localparam alu_op_t ALU_SUB = 3'd1;
	localparam alu_op_t ALU_AND = 3'd2;
	localparam alu_op_t ALU_OR  = 3'd3;
	localparam alu_op_t ALU_XOR = 3'd4;
	localparam alu_op_t ALU_SLT = 3'd5;
	localparam alu_op_t ALU_EQ  = 3'd6;

endpackage

// ===== rtl/rsc_alu.sv =====
// shared 32-bit arithmetic and compare unit
module rsc_alu import rsc_pkg::*; (
	input  alu_op_t     op,
	input  logic [31:0] x,
	input  logic [31:0] y,
	output logic [31:0] res
);

	always_comb begin
		unique case (op)
			ALU_ADD: res = x + y;
			ALU_SUB: res = x - y;
			ALU_AND: res = x & y;
			ALU_OR:  res = x | y;
			ALU_XOR: res = x ^ y;
			ALU_SLT: res = {31'd0, $signed(x) < $signed(y)};
			ALU_EQ:  res = {31'd0, x == y};
			default: res = '0;
		endcase
	end

endmodule

// ===== rtl/rv32i_subset_core.sv =====
// top level of the rv32i subset core: sequencer, register file and byte memory
//
// One transaction per start pulse; busy stays high until the result has been
// produced, and done marks the result for exactly one cycle (it cannot be
// stalled). After reset the byte memory is swept to zero, one byte a cycle,
// and busy stays high until the sweep ends. MEM_BYTES must be a power of
// two: a byte address wraps by keeping its low bits.
// Transaction length is set by the single byte-wide memory port and the
// one-port register file; an execute on a halted core or a faulting pc
// finishes straight from idle. A new transaction can be taken in the cycle
// done is high.
module rv32i_subset_core import rsc_pkg::*; #(
	parameter int MEM_BYTES = MEM_BYTES_DEF,
	parameter int NUM_REGS  = NUM_REGS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  req_type,
	input  logic [15:0] mem_addr,
	input  logic [31:0] load_data,
	input  logic [4:0]  reg_index,
	output logic [31:0] read_data,
	output logic [31:0] pc_value,
	output logic        halted,
	output logic        fault,
	output logic        unsupported,
	output logic        dest_write,
	output logic [4:0]  dest_reg,
	output logic [31:0] dest_value
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam logic [AW-1:0] LAST_BYTE = AW'(MEM_BYTES - 1);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MEMRD = 4'd3;
	localparam logic [3:0] S_MEMWR = 4'd4;
	localparam logic [3:0] S_RREG  = 4'd5;
	localparam logic [3:0] S_RREG2 = 4'd6;
	localparam logic [3:0] S_RA    = 4'd7;
	localparam logic [3:0] S_RB    = 4'd8;
	localparam logic [3:0] S_RC    = 4'd9;
	localparam logic [3:0] S_EXA   = 4'd10;
	localparam logic [3:0] S_EXB   = 4'd11;

	logic [3:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [AW-1:0] ptr_q;
	logic [2:0]    cnt_q;
	logic [1:0]    req_q;
	logic          phase_q;
	logic [4:0]    reg_q;
	logic [31:0]   wdata_q;
	logic [23:0]   word_q;
	logic [31:0]   ins_q;
	logic [31:0]   a_q;
	logic [31:0]   b_q;
	logic [31:0]   res_q;
	logic [31:0]   pc_q;
	logic          halt_q;

	// byte memory
	logic [7:0]    mem [MEM_BYTES];
	logic [7:0]    mem_rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_a;
	logic [7:0]    mem_wd;

	// register file
	logic [31:0]         rf [NUM_REGS];
	logic [NUM_REGS-1:0] rf_vld_q;
	logic [31:0]         rf_rd_q;
	logic                rf_rdv_q;
	logic [4:0]          rf_ra;
	logic                rf_we;
	logic [31:0]         rf_wd;
	logic [31:0]         rf_val;

	// decode
	logic [6:0]  opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] immi, imms, immb, immj, upper;
	logic        ins_zero, unsup, wr, is_mem, taken;

	// shared unit
	alu_op_t     alu_op;
	logic [31:0] alu_x, alu_y, alu_res;
	logic [31:0] req_addr;
	logic [31:0] word_full;
	logic [31:0] next_pc;
	logic [31:0] wb_val;

	rsc_alu u_alu (
		.op  (alu_op),
		.x   (alu_x),
		.y   (alu_y),
		.res (alu_res)
	);

	assign opc   = ins_q[6:0];
	assign rd    = ins_q[11:7];
	assign f3    = ins_q[14:12];
	assign f7    = ins_q[31:25];
	assign immi  = {{20{ins_q[31]}}, ins_q[31:20]};
	assign imms  = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
	assign immb  = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
	assign immj  = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};
	assign upper = ins_q & UPPER_MASK;
	assign ins_zero = (ins_q == 32'd0);

	always_comb begin
		unsup = 1'b0;
		wr    = 1'b0;
		unique case (opc)
			OP_REG: begin
				wr = 1'b1;
				if (!((f7 == 7'd0 && (f3 == F3_ADD || f3 == F3_AND || f3 == F3_OR
						|| f3 == F3_XOR || f3 == F3_SLT)) || (f7 == F7_ALT && f3 == F3_ADD)))
					unsup = 1'b1;
			end
			OP_IMM: begin
				wr = 1'b1;
				if (!(f3 == F3_ADD || f3 == F3_AND || f3 == F3_OR || f3 == F3_XOR
						|| f3 == F3_SLT))
					unsup = 1'b1;
			end
			OP_LOAD: begin
				wr = 1'b1;
				unsup = (f3 != F3_LW);
			end
			OP_STORE: unsup = (f3 != F3_LW);
			OP_BR: unsup = !(f3 == F3_BEQ || f3 == F3_BNE || f3 == F3_BLT || f3 == F3_BGE);
			OP_JAL: wr = 1'b1;
			OP_JALR: begin
				wr = 1'b1;
				unsup = (f3 != 3'd0);
			end
			OP_LUI, OP_AUIPC: wr = 1'b1;
			default: unsup = 1'b1;
		endcase
		if (ins_zero) begin
			unsup = 1'b0;
			wr    = 1'b0;
		end
		if (unsup)
			wr = 1'b0;
	end

	assign is_mem = (opc == OP_LOAD || opc == OP_STORE) && !unsup && !ins_zero;
	// branch compare result sits in bit 0 of res_q
	assign taken  = (opc == OP_BR) && !unsup && !ins_zero && (res_q[0] ^ f3[0]);

	// operand selection for the shared unit
	always_comb begin
		alu_op = ALU_ADD;
		alu_x  = a_q;
		alu_y  = 32'd4;
		if (state_q == S_EXA) begin
			unique case (opc)
				OP_REG, OP_IMM: begin
					alu_y = (opc == OP_REG) ? b_q : immi;
					unique case (f3)
						F3_AND:  alu_op = ALU_AND;
						F3_OR:   alu_op = ALU_OR;
						F3_XOR:  alu_op = ALU_XOR;
						F3_SLT:  alu_op = ALU_SLT;
						default: alu_op = (opc == OP_REG && f7 == F7_ALT) ? ALU_SUB : ALU_ADD;
					endcase
				end
				OP_BR: begin
					alu_y  = b_q;
					alu_op = f3[2] ? ALU_SLT : ALU_EQ;
				end
				OP_LOAD, OP_JALR: alu_y = immi;
				OP_STORE: alu_y = imms;
				OP_JAL: alu_x = pc_q;
				OP_LUI: begin
					alu_x = 32'd0;
					alu_y = upper;
				end
				OP_AUIPC: begin
					alu_x = pc_q;
					alu_y = upper;
				end
				default: alu_y = 32'd4;
			endcase
		end else begin
			alu_x = pc_q;
			priority if (taken)
				alu_y = immb;
			else if (opc == OP_JAL && !ins_zero)
				alu_y = immj;
			else
				alu_y = 32'd4;
		end
	end

	assign req_addr  = {16'd0, mem_addr};
	assign word_full = {mem_rd_q, word_q};
	assign rf_val    = rf_rdv_q ? rf_rd_q : 32'd0;

	// jalr target was formed in the first execute cycle, link value now
	always_comb begin
		if (opc == OP_JALR && !unsup && !ins_zero) begin
			next_pc = {res_q[31:1], 1'b0};
			wb_val  = alu_res;
		end else begin
			next_pc = alu_res;
			wb_val  = res_q;
		end
	end

	// memory port control
	always_comb begin
		mem_we = 1'b0;
		mem_a  = ptr_q;
		mem_wd = wdata_q[{cnt_q[1:0], 3'b000} +: 8];
		if (state_q == S_CLR) begin
			mem_we = 1'b1;
			mem_a  = clr_q;
			mem_wd = 8'd0;
		end else if (state_q == S_MEMWR) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_a] <= mem_wd;
		mem_rd_q <= mem[mem_a];
	end

	always_comb begin
		unique case (state_q)
			S_RA:    rf_ra = ins_q[19:15];
			S_RB:    rf_ra = ins_q[24:20];
			default: rf_ra = reg_q;
		endcase
	end

	assign rf_we = (state_q == S_EXB) && wr && (rd != 5'd0);
	assign rf_wd = wb_val;

	always_ff @(posedge clk) begin
		if (rf_we)
			rf[rd] <= rf_wd;
		rf_rd_q <= rf[rf_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			rf_rdv_q <= 1'b0;
		end else begin
			if (rf_we)
				rf_vld_q[rd] <= 1'b1;
			rf_rdv_q <= rf_vld_q[rf_ra];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			ptr_q       <= '0;
			pc_q        <= '0;
			halt_q      <= 1'b0;
			done        <= 1'b0;
			cnt_q       <= '0;
			phase_q     <= 1'b0;
			req_q       <= REQ_LOAD;
			reg_q       <= '0;
			wdata_q     <= '0;
			word_q      <= '0;
			ins_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			res_q       <= '0;
			read_data   <= '0;
			pc_value    <= '0;
			halted      <= 1'b0;
			fault       <= 1'b0;
			unsupported <= 1'b0;
			dest_write  <= 1'b0;
			dest_reg    <= '0;
			dest_value  <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_BYTE)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						req_q   <= req_type;
						reg_q   <= reg_index;
						wdata_q <= load_data;
						phase_q <= 1'b0;
						cnt_q   <= '0;
						unique case (req_type)
							REQ_LOAD: begin
								ptr_q   <= req_addr[AW-1:0];
								state_q <= S_MEMWR;
							end
							REQ_RDMEM: begin
								ptr_q   <= req_addr[AW-1:0];
								state_q <= S_MEMRD;
							end
							REQ_RDREG: state_q <= S_RREG;
							default: begin
								if (halt_q) begin
									done        <= 1'b1;
									read_data   <= '0;
									pc_value    <= pc_q;
									halted      <= 1'b1;
									fault       <= 1'b0;
									unsupported <= 1'b0;
									dest_write  <= 1'b0;
									dest_reg    <= '0;
									dest_value  <= '0;
								end else if (pc_q >= 32'(MEM_BYTES)) begin
									halt_q      <= 1'b1;
									done        <= 1'b1;
									read_data   <= '0;
									pc_value    <= pc_q;
									halted      <= 1'b1;
									fault       <= 1'b1;
									unsupported <= 1'b0;
									dest_write  <= 1'b0;
									dest_reg    <= '0;
									dest_value  <= '0;
								end else begin
									ptr_q   <= pc_q[AW-1:0];
									state_q <= S_MEMRD;
								end
							end
						endcase
					end
				end
				S_MEMRD: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q != 3'd4)
						ptr_q <= (ptr_q == LAST_BYTE) ? '0 : ptr_q + AW'(1);
					unique case (cnt_q)
						3'd1: word_q[7:0]   <= mem_rd_q;
						3'd2: word_q[15:8]  <= mem_rd_q;
						3'd3: word_q[23:16] <= mem_rd_q;
						default: ;
					endcase
					if (cnt_q == 3'd4) begin
						if (req_q == REQ_RDMEM) begin
							state_q     <= S_IDLE;
							done        <= 1'b1;
							read_data   <= word_full;
							pc_value    <= pc_q;
							halted      <= halt_q;
							fault       <= 1'b0;
							unsupported <= 1'b0;
							dest_write  <= 1'b0;
							dest_reg    <= '0;
							dest_value  <= '0;
						end else if (phase_q) begin
							res_q   <= word_full;
							state_q <= S_EXB;
						end else begin
							ins_q   <= word_full;
							state_q <= (word_full == 32'd0) ? S_EXB : S_RA;
						end
					end
				end
				S_MEMWR: begin
					cnt_q <= cnt_q + 3'd1;
					ptr_q <= (ptr_q == LAST_BYTE) ? '0 : ptr_q + AW'(1);
					if (cnt_q == 3'd3) begin
						if (req_q == REQ_LOAD) begin
							state_q     <= S_IDLE;
							done        <= 1'b1;
							read_data   <= '0;
							pc_value    <= pc_q;
							halted      <= halt_q;
							fault       <= 1'b0;
							unsupported <= 1'b0;
							dest_write  <= 1'b0;
							dest_reg    <= '0;
							dest_value  <= '0;
						end else begin
							state_q <= S_EXB;
						end
					end
				end
				S_RREG: state_q <= S_RREG2;
				S_RREG2: begin
					state_q     <= S_IDLE;
					done        <= 1'b1;
					read_data   <= rf_val;
					pc_value    <= pc_q;
					halted      <= halt_q;
					fault       <= 1'b0;
					unsupported <= 1'b0;
					dest_write  <= 1'b0;
					dest_reg    <= '0;
					dest_value  <= '0;
				end
				S_RA: state_q <= S_RB;
				S_RB: begin
					a_q     <= rf_val;
					state_q <= S_RC;
				end
				S_RC: begin
					b_q     <= rf_val;
					state_q <= S_EXA;
				end
				S_EXA: begin
					res_q <= alu_res;
					if (is_mem) begin
						phase_q <= 1'b1;
						wdata_q <= b_q;
						ptr_q   <= alu_res[AW-1:0];
						cnt_q   <= '0;
						if (opc == OP_STORE)
							state_q <= S_MEMWR;
						else
							state_q <= S_MEMRD;
					end else begin
						state_q <= S_EXB;
					end
				end
				S_EXB: begin
					pc_q <= next_pc;
					if (ins_zero)
						halt_q <= 1'b1;
					state_q     <= S_IDLE;
					done        <= 1'b1;
					read_data   <= '0;
					pc_value    <= next_pc;
					halted      <= halt_q | ins_zero;
					fault       <= 1'b0;
					unsupported <= unsup;
					dest_write  <= rf_we;
					dest_reg    <= rf_we ? rd : 5'd0;
					dest_value  <= rf_we ? wb_val : 32'd0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	// every result leaves the sequencer ready for the next transaction
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done asserted while busy");

	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && fault) |-> halted)
		else $error("fault reported without halt");

	a_no_x0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(done && dest_write) |-> (dest_reg != 5'd0))
		else $error("write to x0 reported");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type != REQ_EXEC) |=> busy)
		else $error("non-execute transaction finished without busy");

endmodule

// ===== bench/rv32i_subset_core_tb.sv =====
// self-checking testbench for the rv32i subset core with a shadow-state scoreboard
`timescale 1ns / 100ps

module rv32i_subset_core_tb import rsc_pkg::*;;

	typedef struct {
		logic [31:0] read_data;
		logic [31:0] pc_value;
		logic        halted;
		logic        fault;
		logic        unsupported;
		logic        dest_write;
		logic [4:0]  dest_reg;
		logic [31:0] dest_value;
	} core_result_t;

	class core_shadow;
		bit [31:0] regs [32];
		bit [31:0] pc;
		bit        halt;
		bit [7:0]  mem [MEM_BYTES_DEF];
		core_result_t expected_q [$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function bit [31:0] word_at(bit [31:0] a);
			int unsigned base;
			bit [31:0] v;
			base = a % MEM_BYTES_DEF;
			v = 0;
			for (int i = 0; i < 4; i++)
				v[8*i +: 8] = mem[(base + i) % MEM_BYTES_DEF];
			return v;
		endfunction

		function void put_word(bit [31:0] a, bit [31:0] v);
			int unsigned base;
			base = a % MEM_BYTES_DEF;
			for (int i = 0; i < 4; i++)
				mem[(base + i) % MEM_BYTES_DEF] = v[8*i +: 8];
		endfunction

		// one instruction at the current pc; dry leaves the state alone
		function core_result_t step(bit [31:0] ins, bit dry);
			core_result_t r;
			bit [6:0] op, f7;
			bit [4:0] rd;
			bit [2:0] f3;
			bit [31:0] a, b, immi, imms, immb, immj, nxt, val;
			bit wr, hl, taken;
			r = '{default: 0};
			op = ins[6:0];
			rd = ins[11:7];
			f3 = ins[14:12];
			f7 = ins[31:25];
			a = regs[ins[19:15]];
			b = regs[ins[24:20]];
			immi = {{20{ins[31]}}, ins[31:20]};
			imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
			immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
			immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
			nxt = pc + 4;
			wr = 0;
			val = 0;
			hl = halt;
			taken = 0;
			if (ins == 0) begin
				hl = 1;
			end else begin
				case (op)
					OP_REG: begin
						wr = 1;
						if (f3 == F3_ADD && f7 == 0) val = a + b;
						else if (f3 == F3_ADD && f7 == F7_ALT) val = a - b;
						else if (f3 == F3_AND && f7 == 0) val = a & b;
						else if (f3 == F3_OR && f7 == 0) val = a | b;
						else if (f3 == F3_XOR && f7 == 0) val = a ^ b;
						else if (f3 == F3_SLT && f7 == 0) val = {31'd0, $signed(a) < $signed(b)};
						else begin
							wr = 0;
							r.unsupported = 1;
						end
					end
					OP_IMM: begin
						wr = 1;
						if (f3 == F3_ADD) val = a + immi;
						else if (f3 == F3_AND) val = a & immi;
						else if (f3 == F3_OR) val = a | immi;
						else if (f3 == F3_XOR) val = a ^ immi;
						else if (f3 == F3_SLT) val = {31'd0, $signed(a) < $signed(immi)};
						else begin
							wr = 0;
							r.unsupported = 1;
						end
					end
					OP_LOAD: begin
						if (f3 == F3_LW) begin
							wr = 1;
							val = word_at(a + immi);
						end else r.unsupported = 1;
					end
					OP_STORE: begin
						if (f3 == F3_LW) begin
							if (!dry) put_word(a + imms, b);
						end else r.unsupported = 1;
					end
					OP_BR: begin
						if (f3 == F3_BEQ) taken = (a == b);
						else if (f3 == F3_BNE) taken = (a != b);
						else if (f3 == F3_BLT) taken = $signed(a) < $signed(b);
						else if (f3 == F3_BGE) taken = !($signed(a) < $signed(b));
						else r.unsupported = 1;
						if (taken) nxt = pc + immb;
					end
					OP_JAL: begin
						wr = 1;
						val = pc + 4;
						nxt = pc + immj;
					end
					OP_JALR: begin
						if (f3 == 0) begin
							wr = 1;
							val = pc + 4;
							nxt = (a + immi) & ~32'd1;
						end else r.unsupported = 1;
					end
					OP_LUI: begin
						wr = 1;
						val = ins & UPPER_MASK;
					end
					OP_AUIPC: begin
						wr = 1;
						val = pc + (ins & UPPER_MASK);
					end
					default: r.unsupported = 1;
				endcase
			end
			if (wr && rd != 0) begin
				r.dest_write = 1;
				r.dest_reg = rd;
				r.dest_value = val;
				if (!dry) regs[rd] = val;
			end
			if (!dry) begin
				pc = nxt;
				halt = hl;
			end
			r.pc_value = nxt;
			r.halted = hl;
			return r;
		endfunction

		function void note(bit [1:0] rq, bit [15:0] ad, bit [31:0] dt, bit [4:0] ix);
			core_result_t r;
			r = '{default: 0};
			case (rq)
				REQ_LOAD: put_word(ad, dt);
				REQ_RDREG: r.read_data = regs[ix];
				REQ_RDMEM: r.read_data = word_at(ad);
				REQ_EXEC: begin
					if (halt) begin
					end else if (pc >= MEM_BYTES_DEF) begin
						r.fault = 1;
						halt = 1;
					end else r = step(word_at(pc), 0);
				end
			endcase
			r.pc_value = pc;
			r.halted = halt;
			expected_q.push_back(r);
		endfunction

		function void cmp(string name, bit [31:0] e, bit [31:0] a);
			if (e !== a) begin
				$error("%s mismatch: expected %h, got %h", name, e, a);
				errors++;
			end
		endfunction

		function void check(core_result_t act);
			core_result_t e;
			if (expected_q.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			cmp("read_data", e.read_data, act.read_data);
			cmp("pc_value", e.pc_value, act.pc_value);
			cmp("halted", e.halted, act.halted);
			cmp("fault", e.fault, act.fault);
			cmp("unsupported", e.unsupported, act.unsupported);
			cmp("dest_write", e.dest_write, act.dest_write);
			cmp("dest_reg", e.dest_reg, act.dest_reg);
			cmp("dest_value", e.dest_value, act.dest_value);
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy, done;
	logic [1:0]  req_type = 0;
	logic [15:0] mem_addr = 0;
	logic [31:0] load_data = 0;
	logic [4:0]  reg_index = 0;
	logic [31:0] read_data, pc_value, dest_value;
	logic        halted, fault, unsupported, dest_write;
	logic [4:0]  dest_reg;

	core_shadow sb = new();
	int sent = 0;
	int idle_pct = 0;

	rv32i_subset_core dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check('{read_data, pc_value, halted, fault, unsupported, dest_write,
				dest_reg, dest_value});
	end

	task automatic pause(int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send(logic [1:0] rq, logic [15:0] ad, logic [31:0] dt, logic [4:0] ix);
		start <= 1;
		req_type <= rq;
		mem_addr <= ad;
		load_data <= dt;
		reg_index <= ix;
		do @(posedge clk); while (busy);
		sb.note(rq, ad, dt, ix);
		sent++;
		if ($urandom_range(0, 99) < idle_pct) pause($urandom_range(1, 6));
	endtask

	// place the word at the current pc, then execute it
	task automatic run_ins(logic [31:0] ins);
		send(REQ_LOAD, sb.pc[15:0], ins, 5'($urandom));
		send(REQ_EXEC, 16'($urandom), $urandom, 5'($urandom));
	endtask

	function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
			logic [4:0] rd, logic [6:0] op);
		return {imm, rs1, f3, rd, op};
	endfunction

	function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
	endfunction

	function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
			logic [2:0] f3);
		return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BR};
	endfunction

	function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
		return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
	endfunction

	function automatic logic [2:0] some_f3(logic [2:0] good);
		return ($urandom_range(0, 5) == 0) ? 3'($urandom) : good;
	endfunction

	function automatic logic [31:0] pick_instr(logic [31:0] pc);
		logic [31:0] tgt;
		logic [6:0] f7;
		logic [2:0] f3;
		f3 = 3'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				f7 = ($urandom_range(0, 7) == 0) ? 7'($urandom) :
					(f3 == F3_ADD && $urandom_range(0, 1)) ? F7_ALT : 7'd0;
				return enc_r(f7, 5'($urandom), 5'($urandom), f3, 5'($urandom), OP_REG);
			end
			1: return enc_i(12'($urandom), 5'($urandom), f3, 5'($urandom), OP_IMM);
			2: return enc_i(12'($urandom), 5'($urandom), some_f3(F3_LW), 5'($urandom),
				OP_LOAD);
			3: return enc_s(12'($urandom), 5'($urandom), 5'($urandom), some_f3(F3_LW));
			4: return enc_b({12'($urandom), 1'b0}, 5'($urandom_range(0, 3)),
				5'($urandom_range(0, 3)), f3);
			5: begin
				tgt = {31'($urandom_range(0, 32767)), 1'b0};
				return enc_j(21'(tgt - pc), 5'($urandom));
			end
			6: return enc_i($urandom_range(0, 1) ? 12'($urandom) : 12'($urandom_range(0, 2047)),
				$urandom_range(0, 1) ? 5'd0 : 5'($urandom), some_f3(3'd0), 5'($urandom),
				OP_JALR);
			7: return {20'($urandom), 5'($urandom), OP_LUI};
			8: return {20'($urandom), 5'($urandom), OP_AUIPC};
			default: return $urandom;
		endcase
	endfunction

	// a word that keeps the core running with the pc inside memory
	function automatic bit keeps_running(logic [31:0] ins);
		core_result_t r;
		if (ins == 0) return 0;
		r = sb.step(ins, 1);
		return r.pc_value < MEM_BYTES_DEF;
	endfunction

	initial begin
		#40_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [31:0] ins;
		int tries, roll;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, every op class but auipc, wraparound, x0 and jalr self-link
		send(REQ_RDREG, 0, 0, 31);
		send(REQ_LOAD, 16'hFFFE, 32'hA5C3_0FF1, 0);
		send(REQ_RDMEM, 16'hFFFE, 32'hFFFF_FFFF, 0);
		run_ins({20'h80000, 5'd5, OP_LUI});
		run_ins(enc_i(12'h800, 0, F3_ADD, 6, OP_IMM));
		run_ins(enc_i(12'h7FF, 0, F3_ADD, 7, OP_IMM));
		run_ins(enc_r(F7_ALT, 7, 6, F3_ADD, 8, OP_REG));
		run_ins(enc_r(0, 7, 5, F3_SLT, 9, OP_REG));
		run_ins(enc_b(13'd8, 7, 5, F3_BLT));
		run_ins(enc_s(12'hFFE, 5, 0, F3_LW));
		run_ins(enc_i(12'hFFE, 0, F3_LW, 10, OP_LOAD));
		run_ins(enc_j(21'd8, 1));
		run_ins(enc_i(12'd0, 1, 3'd0, 1, OP_JALR));
		run_ins(enc_r(7'h01, 2, 3, F3_ADD, 4, OP_REG));
		run_ins(enc_r(0, 7, 7, F3_ADD, 0, OP_REG));

		while (sent < 1500) begin
			case ((sent / 250) % 3)
				0: idle_pct = 0;
				1: idle_pct = 57;
				default: idle_pct = 9;
			endcase
			roll = $urandom_range(0, 99);
			if (roll < 8) send(REQ_LOAD, 16'($urandom), $urandom, 5'($urandom));
			else if (roll < 14) send(REQ_RDREG, 16'($urandom), $urandom, 5'($urandom));
			else if (roll < 20) send(REQ_RDMEM, 16'($urandom), $urandom, 5'($urandom));
			else begin
				ins = sb.word_at(sb.pc);
				if (keeps_running(ins) && $urandom_range(0, 3) == 0) begin
					send(REQ_EXEC, 16'($urandom), $urandom, 5'($urandom));
				end else begin
					tries = 0;
					do begin
						ins = pick_instr(sb.pc);
						tries++;
					end while (!keeps_running(ins) && tries < 64);
					if (!keeps_running(ins)) ins = enc_i(12'd1, 0, F3_ADD, 1, OP_IMM);
					run_ins(ins);
				end
			end
		end

		// jump past the end of memory: fault, then a halted core ignores execute
		idle_pct = 0;
		run_ins(enc_j(21'h10000, 3));
		send(REQ_EXEC, 0, 0, 0);
		send(REQ_EXEC, 16'hFFFF, 32'hFFFF_FFFF, 31);
		send(REQ_RDREG, 0, 0, 3);
		pause(1);

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/rsc_pkg.sv
rtl/rsc_alu.sv
rtl/rv32i_subset_core.sv
bench/rv32i_subset_core_tb.sv
